@@ hdl/box_muller_gaussian_generator_macros.svh @@
// assertion shorthands shared by the rtl, clocked on clk and quiet during rst
`ifndef BOX_MULLER_GAUSSIAN_GENERATOR_MACROS_SVH
`define BOX_MULLER_GAUSSIAN_GENERATOR_MACROS_SVH

// condition holds in the same cycle
`define BMG_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds in the following cycle
`define BMG_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/bmg_pkg.sv @@
`default_nettype none

package bmg_pkg;

  localparam int SAMPLE_W = 24;
  localparam int MEAN_W   = 24;
  localparam int SPREAD_W = 16;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MEAN   = 1'b0,
    CFG_SPREAD = 1'b1
  } cfg_reg_e;

  // log2 in Q30 with a 5-bit exponent
  localparam int L_W = 35;
  // -2 ln(u) scaled back to Q30
  localparam int V_W = 36;
  localparam int RAD_W = 62;
  localparam int ROOT_W = 31;
  localparam int REM_W = ROOT_W + 2;

  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] TWO_LN2_Q28 = 32'd372130559;

  // exact reciprocals for 31-bit dividends: ceil(2^(31+ceil(log2 k)) / k)
  localparam int DIV42_SH = 37;
  localparam int DIV20_SH = 36;
  localparam int DIV6_SH  = 34;
  localparam int DIV56_SH = 37;
  localparam int DIV30_SH = 36;
  localparam int DIV12_SH = 35;
  localparam logic [31:0] DIV42_MUL = 32'(((64'd1 << DIV42_SH) + 64'd41) / 64'd42);
  localparam logic [31:0] DIV20_MUL = 32'(((64'd1 << DIV20_SH) + 64'd19) / 64'd20);
  localparam logic [31:0] DIV6_MUL  = 32'(((64'd1 << DIV6_SH) + 64'd5) / 64'd6);
  localparam logic [31:0] DIV56_MUL = 32'(((64'd1 << DIV56_SH) + 64'd55) / 64'd56);
  localparam logic [31:0] DIV30_MUL = 32'(((64'd1 << DIV30_SH) + 64'd29) / 64'd30);
  localparam logic [31:0] DIV12_MUL = 32'(((64'd1 << DIV12_SH) + 64'd11) / 64'd12);

  typedef logic signed [31:0] trig_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic              vld;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_lane_t;

  // log2 of the all-ones code, evaluated at elaboration
  function automatic logic [L_W-1:0] log2_q30_ones(input int bits);
    longint unsigned d;
    longint unsigned m;
    logic [29:0] f;
    int e;
    d = (64'd1 << bits) - 64'd1;
    e = bits - 1;
    if (e > 30) m = d >> (e - 30);
    else m = d << (30 - e);
    f = '0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      f = {f[28:0], 1'b0};
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    return {5'(e), f};
  endfunction

endpackage

`default_nettype wire

@@ hdl/bmg_if.sv @@
`default_nettype none

interface bmg_req_if #(parameter int UNIFORM_BITS = 16);
  logic                    valid;
  logic                    ready;
  logic [UNIFORM_BITS-1:0] uniform_a;
  logic [UNIFORM_BITS-1:0] uniform_b;
  modport source (output valid, output uniform_a, output uniform_b, input ready);
  modport sink (input valid, input uniform_a, input uniform_b, output ready);
endinterface

interface bmg_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] sample;
  logic               second_of_pair;
  modport source (output valid, output sample, output second_of_pair, input ready);
  modport sink (input valid, input sample, input second_of_pair, output ready);
endinterface

interface bmg_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/bmg_log_unit.sv @@
`default_nettype none

module bmg_log_unit
  import bmg_pkg::*;
#(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [UNIFORM_BITS-1:0] code,
  output unit_stat_t              stat,
  output logic [L_W-1:0]          log_diff
);

  localparam logic [L_W-1:0] LOG_FULL = log2_q30_ones(UNIFORM_BITS);
  localparam int WIDE_W = UNIFORM_BITS + 31;

  typedef enum logic [1:0] {LG_IDLE, LG_NORM, LG_SQ, LG_DONE} lg_state_t;

  lg_state_t               state;
  logic [UNIFORM_BITS-1:0] nrm;
  logic [5:0]              shifts;
  logic [30:0]             m;
  logic [29:0]             f;
  logic [4:0]              cnt;
  logic [WIDE_W-1:0]       wide;
  logic [61:0]             sq;
  logic [31:0]             sq_hi;
  logic [4:0]              expo;

  assign wide  = {nrm, 31'b0};
  assign sq    = 62'(m) * 62'(m);
  assign sq_hi = sq[61:30];
  assign expo  = 5'(UNIFORM_BITS - 1 - int'(shifts));

  assign log_diff  = LOG_FULL - {expo, f};
  assign stat.busy = (state == LG_NORM) || (state == LG_SQ);
  assign stat.done = (state == LG_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LG_IDLE;
    end else begin
      unique case (state)
        LG_IDLE, LG_DONE: begin
          if (start) begin
            nrm    <= code;
            shifts <= '0;
            state  <= LG_NORM;
          end
        end
        LG_NORM: begin
          // coarse steps of eight, then single bits
          if (nrm[UNIFORM_BITS-1]) begin
            m     <= wide[WIDE_W-1 -: 31];
            f     <= '0;
            cnt   <= '0;
            state <= LG_SQ;
          end else if (nrm[UNIFORM_BITS-1 -: 8] == 8'd0) begin
            nrm    <= nrm << 8;
            shifts <= shifts + 6'd8;
          end else begin
            nrm    <= nrm << 1;
            shifts <= shifts + 6'd1;
          end
        end
        LG_SQ: begin
          if (sq_hi[31]) begin
            m <= sq_hi[31:1];
            f <= {f[28:0], 1'b1};
          end else begin
            m <= sq_hi[30:0];
            f <= {f[28:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd29) state <= LG_DONE;
        end
        default: state <= LG_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/bmg_trig_unit.sv @@
`default_nettype none

module bmg_trig_unit
  import bmg_pkg::*;
#(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [UNIFORM_BITS-1:0] code,
  output unit_stat_t              stat,
  output trig_t                   cos_val,
  output trig_t                   sin_val
);

  localparam int REP = (32 + UNIFORM_BITS - 1) / UNIFORM_BITS;

  typedef enum logic [4:0] {
    TS_IDLE, TS_X, TS_X2, TS_S1, TS_SP1, TS_S2, TS_SP2, TS_S3, TS_SIN,
    TS_C1, TS_CP1, TS_C2, TS_CP2, TS_C3, TS_CP3, TS_COS, TS_DONE
  } step_t;

  step_t                       step;
  logic [REP*UNIFORM_BITS-1:0] rep;
  logic [31:0]                 phase;
  logic [29:0]                 frac;
  logic                        swap_next;
  logic [1:0]                  quad;
  logic                        swap;
  logic [29:0]                 g, x, x2, q;
  logic [30:0]                 t, s, c;
  logic [31:0]                 mul_a, mul_b;
  logic [63:0]                 prod;
  logic [30:0]                 ca, sa;

  // code/(2^n-1) is the code repeated as a binary fraction
  assign rep       = {REP{code}};
  assign phase     = (code == {UNIFORM_BITS{1'b1}}) ? 32'd0 : rep[REP*UNIFORM_BITS-1 -: 32];
  assign frac      = phase[29:0];
  assign swap_next = frac > 30'h2000_0000;

  always_comb begin
    unique case (step)
      TS_X:   begin mul_a = {2'b0, g};  mul_b = HALF_PI_Q30; end
      TS_X2:  begin mul_a = {2'b0, x};  mul_b = {2'b0, x};   end
      TS_S1:  begin mul_a = {2'b0, x2}; mul_b = DIV42_MUL;   end
      TS_S2:  begin mul_a = {2'b0, q};  mul_b = DIV20_MUL;   end
      TS_S3:  begin mul_a = {2'b0, q};  mul_b = DIV6_MUL;    end
      TS_SIN: begin mul_a = {2'b0, x};  mul_b = {1'b0, t};   end
      TS_C1:  begin mul_a = {2'b0, x2}; mul_b = DIV56_MUL;   end
      TS_C2:  begin mul_a = {2'b0, q};  mul_b = DIV30_MUL;   end
      TS_C3:  begin mul_a = {2'b0, q};  mul_b = DIV12_MUL;   end
      TS_SP1, TS_SP2, TS_CP1, TS_CP2, TS_CP3: begin
        mul_a = {2'b0, x2};
        mul_b = {1'b0, t};
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= TS_IDLE;
    end else begin
      if (start) begin
        quad <= phase[31:30];
        swap <= swap_next;
        g    <= swap_next ? 30'(Q30_ONE - 31'(frac)) : frac;
        step <= TS_X;
      end else if (step != TS_IDLE && step != TS_DONE) begin
        step <= step_t'(5'(step) + 5'd1);
      end
      unique case (step)
        TS_X:   x  <= 30'((prod + 64'h2000_0000) >> 30);
        TS_X2:  x2 <= prod[59:30];
        TS_S1:  t  <= Q30_ONE - 31'(prod >> DIV42_SH);
        TS_S2:  t  <= Q30_ONE - 31'(prod >> DIV20_SH);
        TS_S3:  t  <= Q30_ONE - 31'(prod >> DIV6_SH);
        TS_SIN: s  <= prod[60:30];
        TS_C1:  t  <= Q30_ONE - 31'(prod >> DIV56_SH);
        TS_C2:  t  <= Q30_ONE - 31'(prod >> DIV30_SH);
        TS_C3:  t  <= Q30_ONE - 31'(prod >> DIV12_SH);
        TS_COS: c  <= Q30_ONE - 31'(q >> 1);
        TS_SP1, TS_SP2, TS_CP1, TS_CP2, TS_CP3: q <= prod[59:30];
        default: ;
      endcase
    end
  end

  assign ca = swap ? s : c;
  assign sa = swap ? c : s;

  always_comb begin
    unique case (quad)
      2'd0: begin cos_val = trig_t'({1'b0, ca});  sin_val = trig_t'({1'b0, sa});  end
      2'd1: begin cos_val = -trig_t'({1'b0, sa}); sin_val = trig_t'({1'b0, ca});  end
      2'd2: begin cos_val = -trig_t'({1'b0, ca}); sin_val = -trig_t'({1'b0, sa}); end
      default: begin cos_val = trig_t'({1'b0, sa}); sin_val = -trig_t'({1'b0, ca}); end
    endcase
  end

  assign stat.busy = (step != TS_IDLE) && (step != TS_DONE);
  assign stat.done = (step == TS_DONE);

endmodule

`default_nettype wire

@@ hdl/bmg_sqrt_cell.sv @@
`default_nettype none

module bmg_sqrt_cell
  import bmg_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  sqrt_lane_t din,
  output sqrt_lane_t dout
);

  logic [REM_W+1:0] trial_num;
  logic [REM_W+1:0] trial_sub;
  logic             fits;

  // bring down two radicand bits and try the next root bit
  assign trial_num = {din.rem, din.rad[RAD_W-1 -: 2]};
  assign trial_sub = {2'b0, din.root, 2'b01};
  assign fits      = trial_num >= trial_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= din.vld;
    end
    dout.rem  <= fits ? REM_W'(trial_num - trial_sub) : REM_W'(trial_num);
    dout.root <= {din.root[ROOT_W-2:0], fits};
    dout.rad  <= din.rad << 2;
  end

endmodule

`default_nettype wire

@@ hdl/box_muller_gaussian_generator.sv @@
// channel | dir | payload                          | role
// req     | in  | uniform_a, uniform_b             | pair of uniform codes
// rsp     | out | sample, second_of_pair           | scaled normal sample
// cfg     | in  | index, data                      | mean / spread writes
//
// fresh request: the 1 to 9 normalize steps and 30 squaring steps of the log unit
// and the 31 cells of the root chain set the time from acceptance to a valid
// result; the sine/cosine unit runs alongside the log.
// request with a cached value: passes through the spread multiplier and the adder.
// a zero radius code on a fresh request is accepted and gives nothing.
// one request at a time; req waits while an item is in flight, rsp holds its
// register until taken. rst is synchronous and resets control and config state.
`default_nettype none
`include "box_muller_gaussian_generator_macros.svh"

module box_muller_gaussian_generator
  import bmg_pkg::*;
#(
  parameter int UNIFORM_BITS     = 16,
  parameter int NORMAL_FRAC_BITS = 12
) (
  input logic       clk,
  input logic       rst,
  bmg_req_if.sink   req,
  bmg_rsp_if.source rsp,
  bmg_cfg_if.sink   cfg
);

  localparam int ZW       = NORMAL_FRAC_BITS + 4;
  localparam int ZMAG_W   = ZW - 1;
  localparam int SCALE_SH = 58 - NORMAL_FRAC_BITS;
  localparam int SP_W     = ZW + SPREAD_W;
  localparam int QW       = SP_W - NORMAL_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_WAIT, S_LAUNCH, S_SQRT, S_Z0, S_Z1, S_SMUL, S_SADD
  } state_t;

  state_t                    state;
  logic signed [MEAN_W-1:0]  mean;
  logic [SPREAD_W-1:0]       spread;
  logic                      pair_pending;
  logic signed [ZW-1:0]      cached;
  logic signed [ZW-1:0]      z0;
  logic [ROOT_W-1:0]         radius;
  logic [V_W-1:0]            vval;
  logic                      second;
  logic [QW-1:0]             sq;
  logic                      sneg;
  logic                      rsp_valid;
  logic signed [SAMPLE_W-1:0] rsp_sample;
  logic                      rsp_second;

  logic       req_fire;
  logic       start;
  logic       out_free;
  unit_stat_t log_stat;
  unit_stat_t trig_stat;
  logic [L_W-1:0] log_l;
  trig_t      cos_val;
  trig_t      sin_val;
  logic [63:0] vprod;

  sqrt_lane_t lane [0:ROOT_W];

  trig_t               tsel;
  logic                tneg;
  logic [30:0]         tmag;
  logic [61:0]         rprod;
  logic [61:0]         rround;
  logic [ZMAG_W-1:0]   zmag;
  logic signed [ZW-1:0] znext;

  logic signed [ZW-1:0] zsel;
  logic                 zneg;
  logic [ZW-1:0]        zabs;
  logic [SP_W-1:0]      sprod;
  logic [QW-1:0]        sq_next;

  logic [25:0]          qext;
  logic signed [25:0]   sum;
  logic signed [SAMPLE_W-1:0] sat;

  assign req_fire  = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign start     = req_fire && !pair_pending && (req.uniform_a != '0);
  assign out_free  = !rsp_valid || rsp.ready;

  assign rsp.valid          = rsp_valid;
  assign rsp.sample         = rsp_sample;
  assign rsp.second_of_pair = rsp_second;
  assign cfg.ready          = 1'b1;

  bmg_log_unit #(.UNIFORM_BITS(UNIFORM_BITS)) u_log (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .code     (req.uniform_a),
    .stat     (log_stat),
    .log_diff (log_l)
  );

  bmg_trig_unit #(.UNIFORM_BITS(UNIFORM_BITS)) u_trig (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .code    (req.uniform_b),
    .stat    (trig_stat),
    .cos_val (cos_val),
    .sin_val (sin_val)
  );

  // -2 ln(u1) in Q58
  assign vprod = 64'(log_l) * 64'(TWO_LN2_Q28);

  assign lane[0].vld  = (state == S_LAUNCH);
  assign lane[0].rem  = '0;
  assign lane[0].root = '0;
  assign lane[0].rad  = {vval, 26'b0};

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    bmg_sqrt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (lane[i]),
      .dout (lane[i+1])
    );
  end

  // r times cosine or sine, rounded half away from zero
  assign tsel   = (state == S_Z1) ? sin_val : cos_val;
  assign tneg   = tsel[31];
  assign tmag   = tneg ? 31'(-tsel) : 31'(tsel);
  assign rprod  = 62'(radius) * 62'(tmag);
  assign rround = rprod + (62'd1 << (SCALE_SH - 1));
  assign zmag   = ZMAG_W'(rround >> SCALE_SH);
  assign znext  = tneg ? -$signed({1'b0, zmag}) : $signed({1'b0, zmag});

  assign zsel    = second ? cached : z0;
  assign zneg    = zsel[ZW-1];
  assign zabs    = zneg ? ZW'(-zsel) : ZW'(zsel);
  assign sprod   = SP_W'(zabs) * SP_W'(spread);
  assign sq_next = QW'((sprod + (SP_W'(1) << (NORMAL_FRAC_BITS - 1))) >> NORMAL_FRAC_BITS);

  assign qext = 26'(sq);
  assign sum  = $signed({{2{mean[MEAN_W-1]}}, mean}) + $signed(sneg ? -qext : qext);

  always_comb begin
    priority if (sum > 26'sd8388607) sat = 24'sh7FFFFF;
    else if (sum < -26'sd8388608) sat = 24'sh800000;
    else sat = sum[SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mean         <= '0;
      spread       <= 16'd256;
      pair_pending <= 1'b0;
      cached       <= '0;
      rsp_valid    <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        unique case (cfg_reg_e'(cfg.index))
          CFG_MEAN:   mean   <= cfg.data;
          CFG_SPREAD: spread <= cfg.data[SPREAD_W-1:0];
        endcase
      end
      // the final step reloads the register itself
      if (rsp_valid && rsp.ready && state != S_SADD) rsp_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            if (pair_pending) begin
              second       <= 1'b1;
              pair_pending <= 1'b0;
              state        <= S_SMUL;
            end else if (start) begin
              second <= 1'b0;
              state  <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (log_stat.done && trig_stat.done) begin
            vval  <= V_W'((vprod + (64'd1 << 27)) >> 28);
            state <= S_LAUNCH;
          end
        end
        S_LAUNCH: state <= S_SQRT;
        S_SQRT: begin
          if (lane[ROOT_W].vld) begin
            radius <= lane[ROOT_W].root;
            state  <= S_Z0;
          end
        end
        S_Z0: begin
          z0    <= znext;
          state <= S_Z1;
        end
        S_Z1: begin
          cached       <= znext;
          pair_pending <= 1'b1;
          state        <= S_SMUL;
        end
        S_SMUL: begin
          sq    <= sq_next;
          sneg  <= zneg;
          state <= S_SADD;
        end
        S_SADD: begin
          if (out_free) begin
            rsp_valid  <= 1'b1;
            rsp_sample <= sat;
            rsp_second <= second;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BMG_CHECK_NOW(a_root_only_when_waiting, lane[ROOT_W].vld, state == S_SQRT, "root chain output outside root wait")
  `BMG_CHECK_NOW(a_units_quiet_in_idle, state == S_IDLE, !log_stat.busy && !trig_stat.busy, "log or trig unit busy while idle")
  `BMG_CHECK_NEXT(a_second_cached, state == S_Z1, pair_pending && state == S_SMUL, "sine value not cached after first sample")
  `BMG_CHECK_NEXT(a_zero_code_dropped, req_fire && !pair_pending && req.uniform_a == '0, state == S_IDLE && !pair_pending, "zero radius code changed state")

endmodule

`default_nettype wire
